// ===== design/sha1_pkg.sv =====
// ============================================================================
// sha1_pkg: shared types, constants and functions of the SHA-1 engine
// Holds the controller state type, memory geometry, the initial chaining
// values, the round constants and the round logic functions.
// ============================================================================
package sha1_pkg;

    // Memory geometry.
    localparam int unsigned BLK_DEPTH   = 16;
    localparam int unsigned BLK_AW      = $clog2(BLK_DEPTH);
    localparam int unsigned CHAIN_DEPTH = 5;
    localparam int unsigned CHAIN_AW    = $clog2(CHAIN_DEPTH);
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned TOTAL_W     = 61;
    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned CNT_W       = $clog2(ROUNDS);

    // Fixed counter and index end points.
    localparam logic [BLK_AW-1:0]   BLK_LAST   = BLK_AW'(BLK_DEPTH - 1);
    localparam logic [BLK_AW-1:0]   LEN_HI_IDX = BLK_AW'(BLK_DEPTH - 2);
    localparam logic [BLK_AW-1:0]   LEN_LO_IDX = BLK_AW'(BLK_DEPTH - 1);
    localparam logic [CNT_W-1:0]    ROUND_LAST = CNT_W'(ROUNDS - 1);
    localparam logic [CNT_W-1:0]    XFER_LAST  = CNT_W'(CHAIN_DEPTH);
    localparam logic [CHAIN_AW-1:0] LAST_IDX   = CHAIN_AW'(CHAIN_DEPTH - 1);

    // Padding marker byte.
    localparam logic [7:0] PAD_MARK = 8'h80;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    // Initial chaining value for one word.
    function automatic logic [WORD_W-1:0] sha1_iv(input logic [CHAIN_AW-1:0] idx);
        logic [WORD_W-1:0] v;
        unique case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            3'd4:    v = 32'hC3D2E1F0;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round constant for one group of twenty rounds.
    function automatic logic [WORD_W-1:0] sha1_k(input logic [1:0] phase);
        logic [WORD_W-1:0] v;
        unique case (phase)
            2'd0: v = 32'h5A827999;
            2'd1: v = 32'h6ED9EBA1;
            2'd2: v = 32'h8F1BBCDC;
            2'd3: v = 32'hCA62C1D6;
        endcase
        return v;
    endfunction

    // Boolean function of a round group.
    function automatic logic [WORD_W-1:0] sha1_f(input logic [1:0] phase,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] d);
        logic [WORD_W-1:0] v;
        unique case (phase)
            2'd0:    v = (b & c) | (~b & d);
            2'd2:    v = (b & c) | (b & d) | (c & d);
            default: v = b ^ c ^ d;
        endcase
        return v;
    endfunction

    // Rotate left by a constant amount.
    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input int unsigned s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

endpackage

// ===== design/sha1_if.sv =====
// ============================================================================
// sha1_if: handshake channels of the SHA-1 engine
// A byte channel into the engine and a digest word channel out of it.
// ============================================================================

// Message byte channel.
interface sha1_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Digest word channel.
interface sha1_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

// ===== design/sha1_hash_engine.sv =====
// ============================================================================
// sha1_hash_engine: SHA-1 over a byte stream
// Packs bytes into a block RAM, compresses each 64-byte block in 80 rounds
// against chaining words held in a second RAM, pads the final block and
// returns the five digest words.
// ============================================================================
//
//  Channel    Dir  Beat contents                          Handshake
//  ---------  ---  -------------------------------------  -----------
//  i_byte     in   data_byte[7:0], last_byte              valid/ready
//  o_digest   out  digest_word[31:0], word_index, last    valid/ready
//
// Bytes are taken while the engine is idle. A full block is then compressed:
// the chaining RAM is read into the working registers, 80 rounds run fed from
// the block RAM, and the working registers are added back into the chaining RAM.
// After the last byte the padding words are written one per cycle, then one
// or two compressions run and the digest is read out of the chaining RAM one
// word at a time. The chaining RAM reads as the initial values until the
// first compression of a message has written it. Output stalls hold the
// digest readout only; a final word waiting at the output does not block
// input.
module sha1_hash_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sha1_byte_if.sink      i_byte,
    sha1_digest_if.source  o_digest
);

    // Controller state.
    sha1_pkg::t_state r_state, n_state;
    logic [sha1_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [sha1_pkg::BLK_AW-1:0]   r_pidx, n_pidx;
    logic [sha1_pkg::TOTAL_W-1:0]  r_total, n_total;
    logic                          r_fresh, n_fresh;
    logic                          r_pad_pend, n_pad_pend;
    logic                          r_mark, n_mark;
    logic                          r_final, n_final;
    logic                          r_out_valid, n_out_valid;
    logic                          r_rd_pend, n_rd_pend;
    logic [sha1_pkg::CHAIN_AW-1:0] r_oidx, n_oidx;

    // Datapath registers.
    logic [sha1_pkg::WORD_W-1:0]   r_acc, n_acc;
    logic [sha1_pkg::WORD_W-1:0]   r_a, r_b, r_c, r_d, r_e;
    logic [sha1_pkg::WORD_W-1:0]   n_a, n_b, n_c, n_d, n_e;
    logic [sha1_pkg::WORD_W-1:0]   r_w [sha1_pkg::BLK_DEPTH];
    logic [sha1_pkg::WORD_W-1:0]   n_w [sha1_pkg::BLK_DEPTH];
    logic [sha1_pkg::WORD_W-1:0]   r_out_word, n_out_word;
    logic [sha1_pkg::CHAIN_AW-1:0] r_out_idx, n_out_idx;
    logic                          r_out_last, n_out_last;

    // Memory ports.
    logic                          blk_we;
    logic [sha1_pkg::BLK_AW-1:0]   blk_waddr, blk_raddr;
    logic [sha1_pkg::WORD_W-1:0]   blk_wdata, blk_rdata;
    logic                          chain_we;
    logic [sha1_pkg::CHAIN_AW-1:0] chain_waddr, chain_raddr;
    logic [sha1_pkg::WORD_W-1:0]   chain_wdata, chain_rdata;

    // Combinational helpers.
    logic                          in_beat;
    logic [5:0]                    cur_pos, new_pos;
    logic [sha1_pkg::WORD_W-1:0]   merged, marker;
    logic                          len_ok;
    logic [sha1_pkg::CHAIN_AW-1:0] prev_idx;
    logic [sha1_pkg::WORD_W-1:0]   chain_word, chain_sum;
    logic [1:0]                    phase;
    logic [sha1_pkg::WORD_W-1:0]   w_new, w_t, t_sum;

    sha1_ram #(.WIDTH(sha1_pkg::WORD_W), .DEPTH(sha1_pkg::BLK_DEPTH)) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (blk_we),
        .i_waddr (blk_waddr),
        .i_wdata (blk_wdata),
        .i_raddr (blk_raddr),
        .o_rdata (blk_rdata)
    );

    sha1_ram #(.WIDTH(sha1_pkg::WORD_W), .DEPTH(sha1_pkg::CHAIN_DEPTH)) u_chain_ram (
        .i_clk   (i_clk),
        .i_we    (chain_we),
        .i_waddr (chain_waddr),
        .i_wdata (chain_wdata),
        .i_raddr (chain_raddr),
        .o_rdata (chain_rdata)
    );

    // Handshake and output port drive.
    assign i_byte.ready         = (r_state == sha1_pkg::S_IDLE);
    assign in_beat              = i_byte.valid && (r_state == sha1_pkg::S_IDLE);
    assign o_digest.valid       = r_out_valid;
    assign o_digest.digest_word = r_out_word;
    assign o_digest.word_index  = r_out_idx;
    assign o_digest.last_word   = r_out_last;

    // Byte packing and padding words.
    assign cur_pos = r_total[5:0];
    assign new_pos = r_total[5:0] + 6'd1;
    assign merged  = (cur_pos[1:0] == 2'd0) ? {i_byte.data_byte, 24'h000000}
                   : r_acc | (32'(i_byte.data_byte) << {~cur_pos[1:0], 3'b000});
    assign marker  = ((cur_pos[1:0] == 2'd0) ? 32'h0 : r_acc)
                   | (32'(sha1_pkg::PAD_MARK) << {~cur_pos[1:0], 3'b000});
    // The length fits in this pass unless the marker lands in the last two words.
    assign len_ok  = !r_mark || (cur_pos[5:3] != 3'b111);

    // Chaining word seen by load and add: initial values until first written.
    assign prev_idx   = r_cnt[sha1_pkg::CHAIN_AW-1:0] - 3'd1;
    assign chain_word = r_fresh ? sha1_pkg::sha1_iv(prev_idx) : chain_rdata;
    assign chain_sum  = chain_word + r_a;

    // Round function with the message schedule window.
    always_comb begin
        if (r_cnt < 7'd20) begin
            phase = 2'd0;
        end else if (r_cnt < 7'd40) begin
            phase = 2'd1;
        end else if (r_cnt < 7'd60) begin
            phase = 2'd2;
        end else begin
            phase = 2'd3;
        end
    end

    assign w_new = sha1_pkg::rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 1);
    assign w_t   = (r_cnt < sha1_pkg::CNT_W'(sha1_pkg::BLK_DEPTH)) ? blk_rdata : w_new;
    assign t_sum = sha1_pkg::rotl(r_a, 5) + sha1_pkg::sha1_f(phase, r_b, r_c, r_d)
                 + r_e + w_t + sha1_pkg::sha1_k(phase);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha1_pkg::S_IDLE: begin
                if (in_beat) begin
                    if (new_pos == 6'd0) begin
                        n_state = sha1_pkg::S_LOAD;
                    end else if (i_byte.last_byte) begin
                        n_state = sha1_pkg::S_PAD;
                    end
                end
            end
            sha1_pkg::S_PAD: begin
                if (r_pidx == sha1_pkg::BLK_LAST) begin
                    n_state = sha1_pkg::S_LOAD;
                end
            end
            sha1_pkg::S_LOAD: begin
                if (r_cnt == sha1_pkg::XFER_LAST) begin
                    n_state = sha1_pkg::S_ROUND;
                end
            end
            sha1_pkg::S_ROUND: begin
                if (r_cnt == sha1_pkg::ROUND_LAST) begin
                    n_state = sha1_pkg::S_ADD;
                end
            end
            sha1_pkg::S_ADD: begin
                if (r_cnt == sha1_pkg::XFER_LAST) begin
                    priority if (r_final) begin
                        n_state = sha1_pkg::S_OUT;
                    end else if (r_pad_pend) begin
                        n_state = sha1_pkg::S_PAD;
                    end else begin
                        n_state = sha1_pkg::S_IDLE;
                    end
                end
            end
            sha1_pkg::S_OUT: begin
                if (r_rd_pend && (r_oidx == sha1_pkg::LAST_IDX)) begin
                    n_state = sha1_pkg::S_IDLE;
                end
            end
            default: n_state = sha1_pkg::S_IDLE;
        endcase
    end

    // State outputs: memory ports and next register values.
    always_comb begin
        n_cnt       = r_cnt;
        n_pidx      = r_pidx;
        n_total     = r_total;
        n_fresh     = r_fresh;
        n_pad_pend  = r_pad_pend;
        n_mark      = r_mark;
        n_final     = r_final;
        n_rd_pend   = r_rd_pend;
        n_oidx      = r_oidx;
        n_acc       = r_acc;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_e         = r_e;
        n_w         = r_w;
        n_out_valid = r_out_valid && !o_digest.ready;
        n_out_word  = r_out_word;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        blk_we      = 1'b0;
        blk_waddr   = r_pidx;
        blk_wdata   = '0;
        blk_raddr   = '0;
        chain_we    = 1'b0;
        chain_waddr = prev_idx;
        chain_wdata = chain_sum;
        chain_raddr = r_cnt[sha1_pkg::CHAIN_AW-1:0];

        unique case (r_state)
            // Pack each byte into its block word and write the word through.
            sha1_pkg::S_IDLE: begin
                if (in_beat) begin
                    blk_we     = 1'b1;
                    blk_waddr  = cur_pos[5:2];
                    blk_wdata  = merged;
                    n_acc      = merged;
                    n_total    = r_total + 61'd1;
                    n_cnt      = '0;
                    n_mark     = 1'b1;
                    n_pad_pend = i_byte.last_byte;
                    n_pidx     = new_pos[5:2];
                end
            end
            // Write marker (if not yet written), zero and, when they fit, length words up to the end of the block.
            sha1_pkg::S_PAD: begin
                blk_we = 1'b1;
                priority if (r_mark && (r_pidx == cur_pos[5:2])) begin
                    blk_wdata = marker;
                end else if (len_ok && (r_pidx == sha1_pkg::LEN_HI_IDX)) begin
                    blk_wdata = r_total[60:29];
                end else if (len_ok && (r_pidx == sha1_pkg::LEN_LO_IDX)) begin
                    blk_wdata = {r_total[28:0], 3'b000};
                end else begin
                    blk_wdata = '0;
                end
                n_pidx = r_pidx + 4'd1;
                if (r_pidx == sha1_pkg::BLK_LAST) begin
                    n_final = len_ok;
                    n_mark  = 1'b0;
                    n_cnt   = '0;
                end
            end
            // Read the chaining words into the working registers.
            sha1_pkg::S_LOAD: begin
                if (r_cnt != '0) begin
                    n_a = r_b;
                    n_b = r_c;
                    n_c = r_d;
                    n_d = r_e;
                    n_e = chain_word;
                end
                if (r_cnt == sha1_pkg::XFER_LAST) begin
                    n_cnt = '0;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            // One round per cycle; the block RAM feeds the first sixteen.
            sha1_pkg::S_ROUND: begin
                blk_raddr = r_cnt[sha1_pkg::BLK_AW-1:0] + 4'd1;
                for (int i = 0; i < sha1_pkg::BLK_DEPTH - 1; i++) begin
                    n_w[i] = r_w[i+1];
                end
                n_w[sha1_pkg::BLK_DEPTH-1] = w_t;
                n_a = t_sum;
                n_b = r_a;
                n_c = sha1_pkg::rotl(r_b, 30);
                n_d = r_c;
                n_e = r_d;
                if (r_cnt == sha1_pkg::ROUND_LAST) begin
                    n_cnt = '0;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            // Add the working registers back into the chaining RAM.
            sha1_pkg::S_ADD: begin
                if (r_cnt != '0) begin
                    chain_we = 1'b1;
                    n_a = r_b;
                    n_b = r_c;
                    n_c = r_d;
                    n_d = r_e;
                end
                if (r_cnt == sha1_pkg::XFER_LAST) begin
                    n_cnt   = '0;
                    n_fresh = r_final;
                    n_pidx  = '0;
                    if (r_final) begin
                        n_final    = 1'b0;
                        n_pad_pend = 1'b0;
                        n_total    = '0;
                        n_oidx     = '0;
                        n_rd_pend  = 1'b0;
                    end
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            // Read the digest out of the chaining RAM into the output register.
            sha1_pkg::S_OUT: begin
                chain_raddr = r_oidx;
                if (r_rd_pend) begin
                    n_out_valid = 1'b1;
                    n_out_word  = chain_rdata;
                    n_out_idx   = r_oidx;
                    n_out_last  = (r_oidx == sha1_pkg::LAST_IDX);
                    n_oidx      = r_oidx + 3'd1;
                    n_rd_pend   = 1'b0;
                end else if (!r_out_valid || o_digest.ready) begin
                    n_rd_pend = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sha1_pkg::S_IDLE;
            r_cnt       <= '0;
            r_pidx      <= '0;
            r_total     <= '0;
            r_fresh     <= 1'b1;
            r_pad_pend  <= 1'b0;
            r_mark      <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_oidx      <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pidx      <= n_pidx;
            r_total     <= n_total;
            r_fresh     <= n_fresh;
            r_pad_pend  <= n_pad_pend;
            r_mark      <= n_mark;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
            r_rd_pend   <= n_rd_pend;
            r_oidx      <= n_oidx;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_a        <= n_a;
        r_b        <= n_b;
        r_c        <= n_c;
        r_d        <= n_d;
        r_e        <= n_e;
        r_w        <= n_w;
        r_out_word <= n_out_word;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

endmodule

// ===== design/sha1_ram.sv =====
// ============================================================================
// sha1_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ============================================================================
module sha1_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sha1_chk.sv =====
// ============================================================================
// sha1_chk: port-level checks of the SHA-1 engine
// Watches both channels of the top level and is bound to it below.
// ============================================================================
module sha1_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_word,
    input logic [2:0]  i_out_index,
    input logic        i_out_last
);

    // A digest beat stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("digest beat dropped before it was taken");

    // A stalled digest beat keeps its contents.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_word) && $stable(i_out_index) && $stable(i_out_last))
        else $error("stalled digest beat changed");

    // The last byte of a message always starts padding or compression.
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("engine took a byte right after the last byte");

    // While digest words other than the final one are pending, no byte is taken.
    a_out_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_index != sha1_pkg::LAST_IDX) |-> !i_in_ready)
        else $error("byte accepted during digest readout");

    // Reset leaves no digest beat pending.
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("digest beat valid after reset");

endmodule

bind sha1_hash_engine sha1_chk u_sha1_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_in_last   (i_byte.last_byte),
    .i_out_valid (o_digest.valid),
    .i_out_ready (o_digest.ready),
    .i_out_word  (o_digest.digest_word),
    .i_out_index (o_digest.word_index),
    .i_out_last  (o_digest.last_word)
);
